// ----- hdl/mbe_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types and constants for the Mandelbrot escape-time block.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int FRAC_BITS = 57;
	localparam int DATA_W    = 64;
	localparam int STEP_W    = 63;
	localparam int PIX_W     = 11;
	localparam int CNT_W     = 16;
	localparam int REG_IDX_W = 3;
	localparam int HALF_W    = DATA_W / 2;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int PP_W      = 2 * (HALF_W + 1);

	// escape when the 65-bit sum of squares reaches 4.0
	localparam int ESC_BIT = FRAC_BITS + 2;

	localparam logic [DATA_W-1:0] X_MIN_RST      = 64'd0 - 64'd107553164861011237;
	localparam logic [DATA_W-1:0] Y_MAX_RST      = 64'd16385896884224813;
	localparam logic [STEP_W-1:0] X_STEP_RST     = 63'd443323088319;
	localparam logic [STEP_W-1:0] Y_STEP_RST     = 63'd246290604622;
	localparam logic [CNT_W-1:0]  ITER_LIMIT_RST = 16'd2500;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_X_MIN      = 3'd0,
		REG_Y_MAX      = 3'd1,
		REG_X_STEP     = 3'd2,
		REG_Y_STEP     = 3'd3,
		REG_ITER_LIMIT = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [DATA_W-1:0] x_min;
		logic [DATA_W-1:0] y_max;
		logic [STEP_W-1:0] x_step;
		logic [STEP_W-1:0] y_step;
		logic [CNT_W-1:0]  iter_limit;
	} cfg_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_CROSS,
		SH_SQUARE
	} shift_t;

	typedef struct packed {
		logic              start;
		shift_t            sh;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} mul_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_XMUL,
		ST_XWAIT,
		ST_YMUL,
		ST_YWAIT,
		ST_CHECK,
		ST_UVMUL,
		ST_UVWAIT,
		ST_UUMUL,
		ST_UUWAIT,
		ST_VVMUL,
		ST_VVWAIT
	} state_t;

endpackage

// ----- hdl/mbe_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe channel interfaces
// Valid/ready channels for pixel words and result words.
// ----------------------------------------------------------------------------
interface mbe_in_if;
	logic                         valid;
	logic                         ready;
	logic [mbe_pkg::PIX_W-1:0]    col;
	logic [mbe_pkg::PIX_W-1:0]    row;

	modport source (output valid, output col, output row, input ready);
	modport sink (input valid, input col, input row, output ready);
endinterface

interface mbe_out_if;
	logic                         valid;
	logic                         ready;
	logic [mbe_pkg::CNT_W-1:0]    iteration_count;
	logic                         escaped;

	modport source (output valid, output iteration_count, output escaped, input ready);
	modport sink (input valid, input iteration_count, input escaped, output ready);
endinterface

// ----- hdl/mbe_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_regs
// Configuration registers: viewport origin, steps and iteration limit.
// ----------------------------------------------------------------------------
module mbe_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mbe_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [mbe_pkg::DATA_W-1:0]      cfg_data,
	output mbe_pkg::cfg_t                   cfg
);

	mbe_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_min      <= mbe_pkg::X_MIN_RST;
			cfg_q.y_max      <= mbe_pkg::Y_MAX_RST;
			cfg_q.x_step     <= mbe_pkg::X_STEP_RST;
			cfg_q.y_step     <= mbe_pkg::Y_STEP_RST;
			cfg_q.iter_limit <= mbe_pkg::ITER_LIMIT_RST;
		end else if (cfg_we) begin
			case (mbe_pkg::reg_idx_t'(cfg_index))
				mbe_pkg::REG_X_MIN: begin
					cfg_q.x_min <= cfg_data;
				end
				mbe_pkg::REG_Y_MAX: begin
					cfg_q.y_max <= cfg_data;
				end
				mbe_pkg::REG_X_STEP: begin
					cfg_q.x_step <= cfg_data[mbe_pkg::STEP_W-1:0];
				end
				mbe_pkg::REG_Y_STEP: begin
					cfg_q.y_step <= cfg_data[mbe_pkg::STEP_W-1:0];
				end
				mbe_pkg::REG_ITER_LIMIT: begin
					cfg_q.iter_limit <= cfg_data[mbe_pkg::CNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/mbe_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_mul
// Shared signed 64x64 multiplier built from one 33x33 multiplier over four
// partial products, with a fixed-point shift on the 128-bit result.
// ----------------------------------------------------------------------------
module mbe_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mbe_pkg::mul_req_t           req,
	output logic                        done,
	output logic [mbe_pkg::DATA_W-1:0]  res
);

	localparam int H = mbe_pkg::HALF_W;

	logic [mbe_pkg::DATA_W-1:0]         a_q;
	logic [mbe_pkg::DATA_W-1:0]         b_q;
	mbe_pkg::shift_t                    sh_q;
	logic                               busy_q;
	logic [1:0]                         cnt_q;
	logic                               pp_vld_q;
	logic [1:0]                         pp_pos_q;
	logic signed [mbe_pkg::PP_W-1:0]    pp_q;
	logic [mbe_pkg::PROD_W-1:0]         acc_q;
	logic                               done_q;

	logic signed [H:0]                  opa;
	logic signed [H:0]                  opb;
	logic signed [mbe_pkg::PP_W-1:0]    pp;
	logic [mbe_pkg::PROD_W-1:0]         ppx;
	logic [mbe_pkg::PROD_W-1:0]         pp_sh;
	logic [mbe_pkg::PROD_W-1:0]         acc_d;

	// high halves are signed, low halves unsigned
	assign opa = cnt_q[1] ? {a_q[mbe_pkg::DATA_W-1], a_q[mbe_pkg::DATA_W-1:H]}
	                      : {1'b0, a_q[H-1:0]};
	assign opb = cnt_q[0] ? {b_q[mbe_pkg::DATA_W-1], b_q[mbe_pkg::DATA_W-1:H]}
	                      : {1'b0, b_q[H-1:0]};
	assign pp  = opa * opb;

	always_comb begin
		ppx = {{(mbe_pkg::PROD_W-mbe_pkg::PP_W){pp_q[mbe_pkg::PP_W-1]}}, pp_q};
		case (pp_pos_q)
			2'd0: begin
				pp_sh = ppx;
			end
			2'd3: begin
				pp_sh = ppx << (2 * H);
			end
			default: begin
				pp_sh = ppx << H;
			end
		endcase
		acc_d = ((pp_pos_q == 2'd0) ? '0 : acc_q) + pp_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= 2'd0;
			pp_vld_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			pp_vld_q <= busy_q;
			done_q   <= pp_vld_q && (pp_pos_q == 2'd3);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q  <= req.a;
			b_q  <= req.b;
			sh_q <= req.sh;
		end
		if (busy_q) begin
			pp_q     <= pp;
			pp_pos_q <= cnt_q;
		end
		if (pp_vld_q) begin
			acc_q <= acc_d;
		end
	end

	always_comb begin
		case (sh_q)
			mbe_pkg::SH_CROSS: begin
				res = acc_q[mbe_pkg::FRAC_BITS-1 +: mbe_pkg::DATA_W];
			end
			mbe_pkg::SH_SQUARE: begin
				res = acc_q[mbe_pkg::FRAC_BITS +: mbe_pkg::DATA_W];
			end
			default: begin
				res = acc_q[mbe_pkg::DATA_W-1:0];
			end
		endcase
	end

	assign done = done_q;

endmodule

// ----- hdl/mandelbrot_escape_iteration.sv -----
`timescale 1ns / 1ps
// one pixel at a time; the next can be taken in the cycle after the result loads
// each iteration runs three products through the shared 4-step multiplier
// plus an escape test; the coordinate setup takes two more products
// reset restores the default viewport and limit and drops any pending result
// ----------------------------------------------------------------------------
// mandelbrot_escape_iteration
// Mandelbrot escape-time iteration in Q7.57 fixed point for one pixel word.
// ----------------------------------------------------------------------------
module mandelbrot_escape_iteration (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mbe_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [mbe_pkg::DATA_W-1:0]      cfg_data,
	mbe_in_if.sink                          pixel,
	mbe_out_if.source                       result
);

	mbe_pkg::cfg_t                  cfg;
	mbe_pkg::mul_req_t              mul_req;
	logic                           mul_done;
	logic [mbe_pkg::DATA_W-1:0]     mul_res;

	mbe_pkg::state_t                state_q;
	mbe_pkg::state_t                state_d;

	logic [mbe_pkg::PIX_W-1:0]      col_q;
	logic [mbe_pkg::PIX_W-1:0]      row_q;
	logic [mbe_pkg::DATA_W-1:0]     x_q;
	logic [mbe_pkg::DATA_W-1:0]     y_q;
	logic [mbe_pkg::DATA_W-1:0]     u_q;
	logic [mbe_pkg::DATA_W-1:0]     v_q;
	logic [mbe_pkg::DATA_W-1:0]     u2_q;
	logic [mbe_pkg::DATA_W-1:0]     v2_q;
	logic [mbe_pkg::CNT_W-1:0]      k_q;

	logic                           o_vld_q;
	logic [mbe_pkg::CNT_W-1:0]      o_cnt_q;
	logic                           o_esc_q;

	logic                           accept;
	logic [mbe_pkg::DATA_W:0]       esc_sum;
	logic                           esc;
	logic                           finish;
	logic                           out_free;
	logic                           load_out;

	mbe_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.res    (mul_res)
	);

	// exact 65-bit escape test
	assign esc_sum  = {u2_q[mbe_pkg::DATA_W-1], u2_q} + {v2_q[mbe_pkg::DATA_W-1], v2_q};
	assign esc      = !esc_sum[mbe_pkg::DATA_W] &&
	                  (|esc_sum[mbe_pkg::DATA_W-1:mbe_pkg::ESC_BIT]);
	assign finish   = esc || (k_q >= cfg.iter_limit);
	assign out_free = !o_vld_q || result.ready;
	assign accept   = pixel.valid && pixel.ready;
	assign load_out = (state_q == mbe_pkg::ST_CHECK) && finish && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				if (pixel.valid) begin
					state_d = mbe_pkg::ST_XMUL;
				end
			end
			mbe_pkg::ST_XMUL: begin
				state_d = mbe_pkg::ST_XWAIT;
			end
			mbe_pkg::ST_XWAIT: begin
				if (mul_done) begin
					state_d = mbe_pkg::ST_YMUL;
				end
			end
			mbe_pkg::ST_YMUL: begin
				state_d = mbe_pkg::ST_YWAIT;
			end
			mbe_pkg::ST_YWAIT: begin
				if (mul_done) begin
					state_d = mbe_pkg::ST_CHECK;
				end
			end
			mbe_pkg::ST_CHECK: begin
				if (!finish) begin
					state_d = mbe_pkg::ST_UVMUL;
				end else if (out_free) begin
					state_d = mbe_pkg::ST_IDLE;
				end
			end
			mbe_pkg::ST_UVMUL: begin
				state_d = mbe_pkg::ST_UVWAIT;
			end
			mbe_pkg::ST_UVWAIT: begin
				if (mul_done) begin
					state_d = mbe_pkg::ST_UUMUL;
				end
			end
			mbe_pkg::ST_UUMUL: begin
				state_d = mbe_pkg::ST_UUWAIT;
			end
			mbe_pkg::ST_UUWAIT: begin
				if (mul_done) begin
					state_d = mbe_pkg::ST_VVMUL;
				end
			end
			mbe_pkg::ST_VVMUL: begin
				state_d = mbe_pkg::ST_VVWAIT;
			end
			mbe_pkg::ST_VVWAIT: begin
				if (mul_done) begin
					state_d = mbe_pkg::ST_CHECK;
				end
			end
			default: begin
				state_d = mbe_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pixel.ready   = (state_q == mbe_pkg::ST_IDLE);
		mul_req.start = 1'b0;
		mul_req.sh    = mbe_pkg::SH_SQUARE;
		mul_req.a     = u_q;
		mul_req.b     = u_q;
		case (state_q)
			mbe_pkg::ST_XMUL: begin
				mul_req.start = 1'b1;
				mul_req.sh    = mbe_pkg::SH_NONE;
				mul_req.a     = mbe_pkg::DATA_W'(col_q);
				mul_req.b     = mbe_pkg::DATA_W'(cfg.x_step);
			end
			mbe_pkg::ST_YMUL: begin
				mul_req.start = 1'b1;
				mul_req.sh    = mbe_pkg::SH_NONE;
				mul_req.a     = mbe_pkg::DATA_W'(row_q);
				mul_req.b     = mbe_pkg::DATA_W'(cfg.y_step);
			end
			mbe_pkg::ST_UVMUL: begin
				mul_req.start = 1'b1;
				mul_req.sh    = mbe_pkg::SH_CROSS;
				mul_req.b     = v_q;
			end
			mbe_pkg::ST_UUMUL: begin
				mul_req.start = 1'b1;
			end
			mbe_pkg::ST_VVMUL: begin
				mul_req.start = 1'b1;
				mul_req.a     = v_q;
				mul_req.b     = v_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::ST_IDLE;
			o_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				o_vld_q <= 1'b1;
			end else if (result.ready) begin
				o_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= pixel.col;
			row_q <= pixel.row;
			k_q   <= '0;
			u_q   <= '0;
			v_q   <= '0;
			u2_q  <= '0;
			v2_q  <= '0;
		end
		case (state_q)
			mbe_pkg::ST_XWAIT: begin
				if (mul_done) begin
					x_q <= cfg.x_min + mul_res;
				end
			end
			mbe_pkg::ST_YWAIT: begin
				if (mul_done) begin
					y_q <= cfg.y_max - mul_res;
				end
			end
			mbe_pkg::ST_UVMUL: begin
				// old u is already captured by the multiplier
				u_q <= u2_q - v2_q + x_q;
			end
			mbe_pkg::ST_UVWAIT: begin
				if (mul_done) begin
					v_q <= mul_res + y_q;
				end
			end
			mbe_pkg::ST_UUWAIT: begin
				if (mul_done) begin
					u2_q <= mul_res;
				end
			end
			mbe_pkg::ST_VVWAIT: begin
				if (mul_done) begin
					v2_q <= mul_res;
					k_q  <= k_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			o_cnt_q <= k_q;
			o_esc_q <= esc;
		end
	end

	assign result.valid           = o_vld_q;
	assign result.iteration_count = o_cnt_q;
	assign result.escaped         = o_esc_q;

endmodule

// ----- hdl/mbe_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_checker
// Port-level checks for the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [mbe_pkg::CNT_W-1:0]   out_count,
	input  logic                        out_esc
);

	// result word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_count) && $stable(out_esc))
		else $error("result word changed while stalled");

	// one pixel at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel port ready right after accept");

	// a new result only comes out of a running iteration
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind mandelbrot_escape_iteration mbe_checker u_mbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_count (result.iteration_count),
	.out_esc   (result.escaped)
);

// ----- bench/mbe_escape_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_escape_checker
// Watches the config port and both channels, keeps its own copy of the
// viewport registers, works out the escape count of every accepted pixel word
// and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module mbe_escape_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mbe_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [mbe_pkg::DATA_W-1:0]      cfg_data,
	mbe_in_if                               pixel,
	mbe_out_if                              result,
	output int                              mismatch_count,
	output int                              words_due
);
	import mbe_pkg::*;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             escaped;
	} escape_word_t;

	localparam logic signed [DATA_W:0] FOUR_Q = 65'sd1 <<< ESC_BIT;

	logic [DATA_W-1:0] x_min_q;
	logic [DATA_W-1:0] y_max_q;
	logic [STEP_W-1:0] x_step_q;
	logic [STEP_W-1:0] y_step_q;
	logic [CNT_W-1:0]  iter_limit_q;

	escape_word_t expected_escapes[$];

	// exact signed product, arithmetic shift, low word kept
	function automatic logic [DATA_W-1:0] fixed_mul(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input int sh);
		logic signed [PROD_W-1:0] wa;
		logic signed [PROD_W-1:0] wb;
		logic signed [PROD_W-1:0] p;
		wa = $signed(a);
		wb = $signed(b);
		p = wa * wb;
		return DATA_W'(p >>> sh);
	endfunction

	// 65-bit sum of squares, so wrapped squares stay negative
	function automatic logic reaches_four(input logic [DATA_W-1:0] u2,
			input logic [DATA_W-1:0] v2);
		logic signed [DATA_W:0] s;
		s = $signed({u2[DATA_W-1], u2}) + $signed({v2[DATA_W-1], v2});
		return s >= FOUR_Q;
	endfunction

	function automatic escape_word_t escape_time(input logic [PIX_W-1:0] c,
			input logic [PIX_W-1:0] r);
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] u;
		logic [DATA_W-1:0] v;
		logic [DATA_W-1:0] u2;
		logic [DATA_W-1:0] v2;
		int unsigned       k;
		logic              gone;
		escape_word_t      w;
		x = x_min_q + DATA_W'(c) * {1'b0, x_step_q};
		y = y_max_q - DATA_W'(r) * {1'b0, y_step_q};
		u = '0;
		v = '0;
		u2 = '0;
		v2 = '0;
		k = 0;
		gone = 1'b0;
		while (k < iter_limit_q && !gone) begin
			if (reaches_four(u2, v2)) begin
				gone = 1'b1;
			end else begin
				v = fixed_mul(u, v, FRAC_BITS - 1) + y;
				u = u2 - v2 + x;
				u2 = fixed_mul(u, u, FRAC_BITS);
				v2 = fixed_mul(v, v, FRAC_BITS);
				k++;
			end
		end
		if (!gone && reaches_four(u2, v2))
			gone = 1'b1;
		w.count = CNT_W'(k);
		w.escaped = gone;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		escape_word_t want;
		if (!arst_n) begin
			x_min_q <= X_MIN_RST;
			y_max_q <= Y_MAX_RST;
			x_step_q <= X_STEP_RST;
			y_step_q <= Y_STEP_RST;
			iter_limit_q <= ITER_LIMIT_RST;
			expected_escapes.delete();
			mismatch_count = 0;
			words_due <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_escapes.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%t: result word with none due: count %0d escaped %0b",
							$realtime, result.iteration_count, result.escaped);
				end else begin
					want = expected_escapes.pop_front();
					if (result.iteration_count !== want.count
							|| result.escaped !== want.escaped) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("%t: escape mismatch: expected count %0d escaped %0b, got count %0d escaped %0b",
								$realtime, want.count, want.escaped,
								result.iteration_count, result.escaped);
					end
				end
			end
			if (pixel.valid && pixel.ready)
				expected_escapes.insert(expected_escapes.size(),
					escape_time(pixel.col, pixel.row));
			if (cfg_we) begin
				case (cfg_index)
					REG_X_MIN: x_min_q <= cfg_data;
					REG_Y_MAX: y_max_q <= cfg_data;
					REG_X_STEP: x_step_q <= cfg_data[STEP_W-1:0];
					REG_Y_STEP: y_step_q <= cfg_data[STEP_W-1:0];
					REG_ITER_LIMIT: iter_limit_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			words_due <= expected_escapes.size();
		end
	end

endmodule

// ----- bench/tb_mandelbrot_escape_iteration.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_iteration
// Drives pixel words through a series of viewports and iteration limits,
// from directed corner points to random views, with random gaps and stalls
// on both channels; the checker beside the block judges every result word.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_iteration;
	import mbe_pkg::*;

	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_WORDS = 220;
	localparam logic [PIX_W-1:0] PIX_MAX = '1;

	localparam logic [DATA_W-1:0] ONE_Q     = 64'd1 << FRAC_BITS;
	localparam logic [DATA_W-1:0] STD_X_MIN = -(ONE_Q << 1);
	localparam logic [DATA_W-1:0] STD_Y_MAX = 64'd5 << (FRAC_BITS - 2);
	localparam logic [DATA_W-1:0] STD_STEP  = 64'd5 << (FRAC_BITS - PIX_W - 1);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0]     cfg_data;
	bit                    gaps_on = 1'b0;
	bit                    hold_go = 1'b0;
	bit                    rx_hold = 1'b0;
	int                    rx_wait;
	int                    cycle_count = 0;
	int                    mismatch_count;
	int                    words_due;

	mbe_in_if  pixel_if ();
	mbe_out_if result_if ();

	mandelbrot_escape_iteration i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel_if),
		.result    (result_if)
	);

	mbe_escape_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.pixel          (pixel_if),
		.result         (result_if),
		.mismatch_count (mismatch_count),
		.words_due      (words_due)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stall after each word while gaps are on, plus one long hold
	always @(posedge clk or negedge arst_n) begin
		int next_wait;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			rx_wait <= 0;
		end else begin
			if (result_if.valid && result_if.ready)
				next_wait = gaps_on ? $urandom_range(0, 3) : 0;
			else
				next_wait = (rx_wait > 0) ? rx_wait - 1 : 0;
			rx_wait <= next_wait;
			result_if.ready <= (next_wait == 0) && !rx_hold;
		end
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	function automatic logic [DATA_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] r);
		int gap;
		gap = gaps_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			pixel_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_if.valid <= 1'b1;
		pixel_if.col <= c;
		pixel_if.row <= r;
		do @(posedge clk); while (!pixel_if.ready);
	endtask

	task automatic send_random_pixel();
		send_pixel(PIX_W'($urandom_range(0, PIX_MAX)), PIX_W'($urandom_range(0, PIX_MAX)));
	endtask

	task automatic wait_idle();
		pixel_if.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
	endtask

	// unused index first, its write must not land anywhere
	task automatic apply_view(input logic [DATA_W-1:0] xm, input logic [DATA_W-1:0] ym,
			input logic [DATA_W-1:0] xs, input logic [DATA_W-1:0] ys,
			input logic [CNT_W-1:0] lim);
		cfg_we <= 1'b1;
		cfg_index <= REG_IDX_W'(int'(REG_ITER_LIMIT) + 1 + $urandom_range(0, 2));
		cfg_data <= rand_word();
		@(posedge clk);
		cfg_index <= REG_X_MIN;
		cfg_data <= xm;
		@(posedge clk);
		cfg_index <= REG_Y_MAX;
		cfg_data <= ym;
		@(posedge clk);
		cfg_index <= REG_X_STEP;
		cfg_data <= xs;
		@(posedge clk);
		cfg_index <= REG_Y_STEP;
		cfg_data <= ys;
		@(posedge clk);
		cfg_index <= REG_ITER_LIMIT;
		cfg_data <= DATA_W'(lim);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int                random_done;
		int                phase_no;
		int                n;
		logic [DATA_W-1:0] xm;
		logic [DATA_W-1:0] ym;
		logic [DATA_W-1:0] xs;
		logic [DATA_W-1:0] ys;
		logic [CNT_W-1:0]  lim;

		pixel_if.valid <= 1'b0;
		pixel_if.col <= '0;
		pixel_if.row <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_X_MIN;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default viewport and limit out of reset
		send_pixel('0, '0);
		send_pixel(PIX_MAX, PIX_MAX);
		wait_idle();

		// full set view, corners and alternating bits
		gaps_on = 1'b1;
		apply_view(STD_X_MIN, STD_Y_MAX, STD_STEP, STD_STEP, 16'd40);
		send_pixel('0, '0);
		send_pixel(PIX_MAX, '0);
		send_pixel('0, PIX_MAX);
		send_pixel(PIX_MAX, PIX_MAX);
		send_pixel(11'h555, 11'h2AA);
		send_pixel(11'h2AA, 11'h555);
		send_pixel(11'd1365, 11'd1024);
		send_pixel(11'd1200, 11'd900);
		wait_idle();

		// zero limit
		apply_view(STD_X_MIN, STD_Y_MAX, STD_STEP, STD_STEP, '0);
		send_pixel('0, '0);
		send_pixel(11'd1000, 11'd1000);
		send_pixel(PIX_MAX, PIX_MAX);
		wait_idle();

		// limit of one: escape on the last step at x = 3 and at x = 5.75
		apply_view(ONE_Q * 3, '0, 64'd11 << (FRAC_BITS - 12), '0, 16'd1);
		send_pixel('0, '0);
		send_pixel(11'd1024, 11'd7);
		wait_idle();

		// x = 9 squares to a negative wrapped value and stays in for a step
		apply_view(ONE_Q * 9, '0, '0, '0, 16'd5);
		send_pixel('0, '0);
		send_pixel(11'd5, 11'd5);
		wait_idle();

		// extreme registers, coordinates wrap
		apply_view(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, '1, '1, 16'd20);
		send_pixel('0, '0);
		send_pixel(PIX_MAX, '0);
		send_pixel('0, PIX_MAX);
		send_pixel(PIX_MAX, PIX_MAX);
		wait_idle();

		// largest limit on a view that escapes at once
		apply_view(64'd5 << (FRAC_BITS - 1), '0, 64'd1 << 30, 64'd1 << 30, '1);
		send_pixel('0, '0);
		send_pixel(PIX_MAX, PIX_MAX);
		send_random_pixel();
		wait_idle();

		random_done = 0;
		phase_no = 0;
		while (random_done < RANDOM_WORDS) begin
			n = $urandom_range(8, 24);
			if ($urandom_range(0, 9) < 7) begin
				xm = -(64'd5 << (FRAC_BITS - 1)) + (DATA_W'($urandom) << 26);
				ym = DATA_W'($urandom) << 25;
				xs = DATA_W'($urandom) << $urandom_range(0, 15);
				ys = DATA_W'($urandom) << $urandom_range(0, 15);
				lim = ($urandom_range(0, 9) == 0) ? '0 : CNT_W'($urandom_range(1, 64));
			end else begin
				xm = rand_word();
				ym = rand_word();
				xs = rand_word();
				ys = rand_word();
				lim = CNT_W'($urandom_range(0, 64));
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			apply_view(xm, ym, xs, ys, lim);
			// block fills up while the result side holds off
			if (phase_no == 1)
				hold_go <= 1'b1;
			repeat (n) send_random_pixel();
			wait_idle();
			random_done += n;
			phase_no++;
		end

		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/mbe_pkg.sv
hdl/mbe_if.sv
hdl/mbe_regs.sv
hdl/mbe_mul.sv
hdl/mandelbrot_escape_iteration.sv
hdl/mbe_checker.sv
bench/mbe_escape_checker.sv
bench/tb_mandelbrot_escape_iteration.sv
